>>> sv/channel_range_reservation_macros.svh
// Assertion macros for the checker of the channel range reservation block
`ifndef CHANNEL_RANGE_RESERVATION_MACROS_SVH
`define CHANNEL_RANGE_RESERVATION_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset
`define CRR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("channel range reservation: check failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset
`define CRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("channel range reservation: check failed");

`endif

>>> sv/crr_pkg.sv
// Types and constants shared by the channel range reservation modules
`timescale 1ns / 1ps

package crr_pkg;

  // Size of the channel space and default table depth
  localparam int unsigned UNIVERSE_CHANNELS = 512;
  localparam int unsigned MAX_SEGMENTS      = 32;

  // Field widths
  localparam int unsigned START_W = 9;
  localparam int unsigned SIZE_W  = 10;
  localparam int unsigned HELD_W  = 6;
  // Stored channel positions reach UNIVERSE_CHANNELS itself (empty append at the end)
  localparam int unsigned CH_W    = 10;
  // Sums of a position and a size
  localparam int unsigned SUM_W   = 11;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_OVERLAP = 3'd1,
    ERR_RANGE   = 3'd2,
    ERR_NOFIT   = 3'd3,
    ERR_FULL    = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DECIDE
  } state_e;

  // One table entry held by a cell
  typedef struct packed {
    logic [CH_W-1:0]   first;
    logic [SIZE_W-1:0] len;
  } entry_t;

  // Request and control broadcast from the controller to every cell
  typedef struct packed {
    logic               clr;
    logic               ins_en;
    logic               autop;
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    entry_t             new_entry;
  } bcast_t;

  // Flags rippled along the chain, one cell per cycle
  typedef struct packed {
    logic            ovl;
    logic [CH_W-1:0] base;
  } link_t;

endpackage

>>> sv/crr_cell.sv
// One cell of the segment chain: holds an entry, ripples flags, shifts on insert
`timescale 1ns / 1ps

module crr_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crr_pkg::bcast_t      bc_i,
  input  logic [CNT_W-1:0]     count_i,
  input  crr_pkg::link_t       link_i,
  input  crr_pkg::entry_t      entry_i,
  input  logic                 after_i,
  output crr_pkg::link_t       link_o,
  output crr_pkg::entry_t      entry_o,
  output logic                 after_o
);

  crr_pkg::entry_t entry_q;
  crr_pkg::link_t  link_q, link_d;

  logic                     in_use;
  logic                     is_last;
  logic [crr_pkg::SUM_W-1:0] seg_end;
  logic [crr_pkg::SUM_W-1:0] req_end;
  logic [crr_pkg::SUM_W-1:0] start_x;
  logic [crr_pkg::SUM_W-1:0] first_x;
  logic                     contains;
  logic                     runs_into;
  logic                     local_ovl;
  logic [crr_pkg::CH_W-1:0] local_base;

  // Local view of the entry against the broadcast request
  always_comb begin
    in_use    = CNT_W'(IDX) < count_i;
    is_last   = CNT_W'(IDX + 1) == count_i;
    first_x   = crr_pkg::SUM_W'(entry_q.first);
    start_x   = crr_pkg::SUM_W'(bc_i.start);
    seg_end   = first_x + crr_pkg::SUM_W'(entry_q.len);
    req_end   = start_x + crr_pkg::SUM_W'(bc_i.size);
    contains  = in_use && (first_x <= start_x) && (start_x < seg_end);
    runs_into = in_use && (first_x > start_x) && (first_x < req_end);
    local_ovl = !bc_i.autop && (contains || runs_into);
    local_base = (in_use && is_last) ? seg_end[crr_pkg::CH_W-1:0] : '0;
  end

  // Insertion point marker: set from the insert position onwards
  assign after_o = !in_use || (!bc_i.autop && (first_x > start_x));

  // Ripple of overlap flag and append base
  always_comb begin
    if (bc_i.clr) begin
      link_d = '0;
    end else begin
      link_d.ovl  = link_i.ovl | local_ovl;
      link_d.base = link_i.base | local_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  // Entry storage: take the new entry at the insert point, the neighbour's beyond it
  always_ff @(posedge clk_i) begin
    if (bc_i.ins_en && after_o) begin
      entry_q <= after_i ? entry_i : bc_i.new_entry;
    end
  end

  assign link_o  = link_q;
  assign entry_o = entry_q;

endmodule

>>> sv/crr_ctrl.sv
// Controller: request capture, sweep timing, decision, table count and result register
`timescale 1ns / 1ps

module crr_ctrl #(
  parameter int unsigned MAX_SEGMENTS = crr_pkg::MAX_SEGMENTS,
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          auto_place_i,
  input  logic [crr_pkg::START_W-1:0]   requested_start_i,
  input  logic [crr_pkg::SIZE_W-1:0]    segment_size_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [crr_pkg::START_W-1:0]   placed_start_o,
  output logic [2:0]                    error_code_o,
  output logic [crr_pkg::HELD_W-1:0]    segments_held_o,
  input  crr_pkg::link_t                tail_i,
  output crr_pkg::bcast_t               bc_o,
  output logic [CNT_W-1:0]              count_o
);

  localparam int unsigned SWP_W = $clog2(MAX_SEGMENTS);
  localparam logic [crr_pkg::SUM_W-1:0] UNIV = crr_pkg::SUM_W'(crr_pkg::UNIVERSE_CHANNELS);

  crr_pkg::state_e state_q, state_d;
  logic [SWP_W-1:0] swp_q, swp_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic                        autop_q;
  logic [crr_pkg::START_W-1:0] start_q;
  logic [crr_pkg::SIZE_W-1:0]  size_q;

  logic                        out_valid_q, out_valid_d;
  logic                        accepted_q;
  logic [crr_pkg::START_W-1:0] placed_q;
  crr_pkg::err_e               err_q;
  logic [crr_pkg::HELD_W-1:0]  held_q;

  logic                        in_take;
  logic                        out_free;
  logic                        commit;
  logic                        clr;
  logic                        swp_done;
  crr_pkg::err_e               err_d;
  logic [crr_pkg::CH_W-1:0]    placed_d;
  logic [crr_pkg::SUM_W-1:0]   req_end;
  logic [crr_pkg::SUM_W-1:0]   auto_end;

  assign out_free = !out_valid_q || !out_stall_i;
  assign swp_done = swp_q == SWP_W'(MAX_SEGMENTS - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crr_pkg::ST_IDLE:   if (in_valid_i) state_d = crr_pkg::ST_SWEEP;
      crr_pkg::ST_SWEEP:  if (swp_done) state_d = crr_pkg::ST_DECIDE;
      crr_pkg::ST_DECIDE: if (out_free) state_d = crr_pkg::ST_IDLE;
      default:            state_d = crr_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    commit     = 1'b0;
    clr        = 1'b0;
    unique case (state_q)
      crr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        clr        = 1'b1;
      end
      crr_pkg::ST_SWEEP: begin
      end
      crr_pkg::ST_DECIDE: begin
        commit = out_free;
      end
      default: begin
      end
    endcase
  end

  assign in_take = in_valid_i && !in_stall_o;

  // Decision from the chain tail, checks in order full, range, overlap, fit; auto placement checks full, then fit
  always_comb begin
    req_end  = crr_pkg::SUM_W'(start_q) + crr_pkg::SUM_W'(size_q);
    auto_end = crr_pkg::SUM_W'(tail_i.base) + crr_pkg::SUM_W'(size_q);
    err_d    = crr_pkg::ERR_OK;
    placed_d = '0;
    if (count_q == CNT_W'(MAX_SEGMENTS)) begin
      err_d = crr_pkg::ERR_FULL;
    end else if (autop_q) begin
      if (auto_end > UNIV) begin
        err_d = crr_pkg::ERR_NOFIT;
      end else begin
        placed_d = tail_i.base;
      end
    end else if (crr_pkg::SUM_W'(start_q) >= UNIV) begin
      err_d = crr_pkg::ERR_RANGE;
    end else if (tail_i.ovl) begin
      err_d = crr_pkg::ERR_OVERLAP;
    end else if (req_end > UNIV) begin
      err_d = crr_pkg::ERR_NOFIT;
    end else begin
      placed_d = crr_pkg::CH_W'(start_q);
    end
  end

  // Broadcast to the cells
  always_comb begin
    bc_o.clr             = clr;
    bc_o.ins_en          = commit && (err_d == crr_pkg::ERR_OK);
    bc_o.autop           = autop_q;
    bc_o.start           = start_q;
    bc_o.size            = size_q;
    bc_o.new_entry.first = placed_d;
    bc_o.new_entry.len   = size_q;
  end

  // Sweep counter, table count and output valid
  always_comb begin
    swp_d = swp_q;
    if (state_q != crr_pkg::ST_SWEEP) begin
      swp_d = '0;
    end else if (!swp_done) begin
      swp_d = swp_q + SWP_W'(1);
    end
    count_d = count_q;
    if (bc_o.ins_en) begin
      count_d = count_q + CNT_W'(1);
    end
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crr_pkg::ST_IDLE;
      swp_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      swp_q       <= swp_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      autop_q <= auto_place_i;
      start_q <= requested_start_i;
      size_q  <= segment_size_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      accepted_q <= err_d == crr_pkg::ERR_OK;
      placed_q   <= placed_d[crr_pkg::START_W-1:0];
      err_q      <= err_d;
      held_q     <= crr_pkg::HELD_W'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = accepted_q;
  assign placed_start_o  = placed_q;
  assign error_code_o    = err_q;
  assign segments_held_o = held_q;
  assign count_o         = count_q;

endmodule

>>> sv/channel_range_reservation.sv
// Top level of the channel range reservation block: controller and chain of segment cells
//
//   channel  direction  handshake              fields
//   request  in         in_valid_i/in_stall_o  auto_place_i, requested_start_i, segment_size_i
//   result   out        out_valid_o/out_stall_i accepted_o, placed_start_o, error_code_o,
//                                               segments_held_o
//
// One item at a time: an item is taken in the idle state, then stays in the sweep state while
// the flag ripple crosses the chain one cell a cycle, then passes through the decide-and-insert state.
// A new item is taken while a finished result still waits in the output register; its
// decide cycle holds until that register is free.
// Reset empties the table at once; cell contents are not cleared.
`timescale 1ns / 1ps

module channel_range_reservation #(
  parameter int unsigned MAX_SEGMENTS = crr_pkg::MAX_SEGMENTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        auto_place_i,
  input  logic [crr_pkg::START_W-1:0] requested_start_i,
  input  logic [crr_pkg::SIZE_W-1:0]  segment_size_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o,
  output logic [crr_pkg::START_W-1:0] placed_start_o,
  output logic [2:0]                  error_code_o,
  output logic [crr_pkg::HELD_W-1:0]  segments_held_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

  crr_pkg::bcast_t  bc;
  logic [CNT_W-1:0] count;
  crr_pkg::link_t   link_chain  [MAX_SEGMENTS];
  crr_pkg::entry_t  entry_chain [MAX_SEGMENTS];
  logic             after_chain [MAX_SEGMENTS];

  crr_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .auto_place_i      (auto_place_i),
    .requested_start_i (requested_start_i),
    .segment_size_i    (segment_size_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accepted_o        (accepted_o),
    .placed_start_o    (placed_start_o),
    .error_code_o      (error_code_o),
    .segments_held_o   (segments_held_o),
    .tail_i            (link_chain[MAX_SEGMENTS-1]),
    .bc_o              (bc),
    .count_o           (count)
  );

  // Row of cells, cell 0 holds the lowest start
  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    crr_pkg::link_t  prev_link;
    crr_pkg::entry_t prev_entry;
    logic            prev_after;

    if (k == 0) begin : g_head
      assign prev_link  = '0;
      assign prev_entry = '0;
      assign prev_after = 1'b0;
    end else begin : g_body
      assign prev_link  = link_chain[k-1];
      assign prev_entry = entry_chain[k-1];
      assign prev_after = after_chain[k-1];
    end

    crr_cell #(
      .IDX   (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bc_i    (bc),
      .count_i (count),
      .link_i  (prev_link),
      .entry_i (prev_entry),
      .after_i (prev_after),
      .link_o  (link_chain[k]),
      .entry_o (entry_chain[k]),
      .after_o (after_chain[k])
    );
  end

endmodule

>>> sv/crr_checker.sv
// Port-level checker for the channel range reservation block, bound to the top level
`timescale 1ns / 1ps
`include "channel_range_reservation_macros.svh"

module crr_checker #(
  parameter int unsigned MAX_SEGMENTS = crr_pkg::MAX_SEGMENTS
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        accepted_o,
  input logic [crr_pkg::START_W-1:0] placed_start_o,
  input logic [2:0]                  error_code_o,
  input logic [crr_pkg::HELD_W-1:0]  segments_held_o
);

  // A stalled result item holds
  `CRR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(placed_start_o) && $stable(error_code_o) && $stable(accepted_o))

  // Accepted items carry the ok code and rejected ones the zero start and an error code
  `CRR_ASSERT_NOW(a_accept_ok, out_valid_o && accepted_o, error_code_o == crr_pkg::ERR_OK)
  `CRR_ASSERT_NOW(a_reject_zero, out_valid_o && !accepted_o,
    placed_start_o == '0 && error_code_o != crr_pkg::ERR_OK)

  // After a taken request the block reports a stall on the input
  `CRR_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)

  // Table-full rejection only with the table at capacity
  `CRR_ASSERT_NOW(a_full_count, out_valid_o && error_code_o == crr_pkg::ERR_FULL,
    segments_held_o == crr_pkg::HELD_W'(MAX_SEGMENTS))

endmodule

bind channel_range_reservation crr_checker #(
  .MAX_SEGMENTS (MAX_SEGMENTS)
) u_crr_checker (.*);
